// ===== hdl/waveform_window_analyzer_macros.svh =====
// Assertion helpers shared by the analyzer RTL.
`ifndef WAVEFORM_WINDOW_ANALYZER_MACROS_SVH
`define WAVEFORM_WINDOW_ANALYZER_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define WWA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define WWA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/wwa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package wwa_pkg;

    // Parameter defaults
    localparam int DEF_WINDOW_DEPTH = 1024;
    localparam int DEF_SAMPLE_BITS  = 14;

    // Fixed field widths
    localparam int IDX_W     = 10;
    localparam int RAW_W     = 14;
    localparam int BOUND_W   = 12;
    localparam int PED_W     = 14;
    localparam int PERIOD_W  = 16;
    localparam int TSTART_W  = 32;
    localparam int SUM_W     = 25;
    localparam int INT_W     = 41;
    localparam int MEAN_W    = 15;
    localparam int PEAK_W    = 15;
    localparam int TIME_W    = 33;

    // Stream and configuration port widths
    localparam int IN_DATA_W  = 48;
    localparam int IN_USER_W  = 1;
    localparam int OUT_FLD_W  = SUM_W + INT_W + MEAN_W + PEAK_W + IDX_W + TIME_W;
    localparam int OUT_DATA_W = 144;
    localparam int OUT_PAD_W  = OUT_DATA_W - OUT_FLD_W;
    localparam int OUT_USER_W = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Item kinds carried in tuser
    localparam logic FUNC_STORE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PEDESTAL = 2'd0,
        CFG_PERIOD   = 2'd1,
        CFG_TSTART   = 2'd2
    } t_cfg_index;

endpackage

`default_nettype wire

// ===== hdl/waveform_window_analyzer.sv =====
// Waveform window analyzer. A store item (tuser = 0) writes one raw sample minus the
// configured pedestal into a WINDOW_DEPTH-entry waveform memory, so samples can stream
// in back to back. A query item (tuser = 1) names a window [window_start, window_end),
// each bound clamped to 0..WINDOW_DEPTH, and yields one result item: sum, integral (sum
// times sample_period), mean truncated toward zero, and the peak sample with its lowest
// index and its time (time_start + sample_period * index); an empty or reversed window
// gives all zeros with mean_ok and peak_ok low. Stores produce no result. A query walks
// the window with one memory read per sample, then runs ACC_W restoring-division steps
// for the mean, ACC_W = SAMPLE_BITS + 1 + clog2(WINDOW_DEPTH + 1) (26 by default), then
// 16 shift-add steps each for the integral and the peak time, then loads the result; the
// walk and the arithmetic share one adder. An empty or reversed window skips the walk and
// the arithmetic. The input side is not ready while a query is in progress, and a result
// that finds the output register still full holds the block in its done state until the
// waiting item is taken. A finished result sits in an output register, so stores and the
// next query are taken while it waits. After reset the memory is zeroed by a clearing
// pass over all WINDOW_DEPTH entries before the first item is taken; configuration
// writes are taken at any time and must only be issued while idle.
`timescale 1ns / 1ps
`default_nettype none
`include "waveform_window_analyzer_macros.svh"

module waveform_window_analyzer #(
    parameter int WINDOW_DEPTH = wwa_pkg::DEF_WINDOW_DEPTH,
    parameter int SAMPLE_BITS  = wwa_pkg::DEF_SAMPLE_BITS
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,

    // Configuration write port
    input  wire                               i_cfg_wr_en,
    input  wire  [wwa_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire  [wwa_pkg::CFG_DATA_W-1:0]    i_cfg_data,

    // Input items
    input  wire                               s_axis_tvalid,
    output logic                              s_axis_tready,
    // [9:0] sample_index, [23:10] raw_sample, [35:24] window_start, [47:36] window_end
    input  wire  [wwa_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // [0] func
    input  wire  [wwa_pkg::IN_USER_W-1:0]     s_axis_tuser,

    // Result items
    output logic                              m_axis_tvalid,
    input  wire                               m_axis_tready,
    // [24:0] window_sum, [65:25] window_integral, [80:66] window_mean,
    // [95:81] peak_value, [105:96] peak_index, [138:106] peak_time, [143:139] zero
    output logic [wwa_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // [0] mean_ok, [1] peak_ok
    output logic [wwa_pkg::OUT_USER_W-1:0]    m_axis_tuser
);

    // Memory address width, bound width (holds WINDOW_DEPTH itself), sample width,
    // accumulator width and shared adder width.
    localparam int AW     = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int BW     = $clog2(WINDOW_DEPTH + 1);
    localparam int SW     = SAMPLE_BITS + 1;
    localparam int ACC_W  = SW + BW;
    localparam int ALU_W  = (ACC_W > wwa_pkg::INT_W) ? ACC_W : wwa_pkg::INT_W;
    localparam int MAX_IT = (ACC_W > wwa_pkg::PERIOD_W) ? ACC_W : wwa_pkg::PERIOD_W;
    localparam int CNT_W  = $clog2(MAX_IT);

    typedef enum logic [2:0] {
        ST_CLEAR,   // zero the waveform memory after reset
        ST_IDLE,    // take store and query items
        ST_WALK,    // read the window, accumulate sum, track peak
        ST_DIV,     // restoring division of |sum| by the sample count
        ST_INT,     // shift-add sum * sample_period
        ST_TIME,    // shift-add time_start + sample_period * peak index
        ST_DONE     // hand the result to the output register
    } t_state;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [wwa_pkg::PED_W-1:0]    r_pedestal;
    logic [wwa_pkg::PERIOD_W-1:0] r_period;
    logic [wwa_pkg::TSTART_W-1:0] r_tstart;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pedestal <= '0;
            r_period   <= wwa_pkg::PERIOD_W'(1);
            r_tstart   <= '0;
        end else if (i_cfg_wr_en) begin
            // Drop writes to indexes beyond the register list.
            unique case (i_cfg_index)
                wwa_pkg::CFG_PEDESTAL: r_pedestal <= i_cfg_data[wwa_pkg::PED_W-1:0];
                wwa_pkg::CFG_PERIOD:   r_period   <= i_cfg_data[wwa_pkg::PERIOD_W-1:0];
                wwa_pkg::CFG_TSTART:   r_tstart   <= i_cfg_data[wwa_pkg::TSTART_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input field unpacking
    // ------------------------------------------------------------------
    logic                               w_func;
    logic [wwa_pkg::IDX_W-1:0]          w_idx;
    logic [wwa_pkg::RAW_W-1:0]          w_raw_in;
    logic signed [wwa_pkg::BOUND_W-1:0] w_wstart;
    logic signed [wwa_pkg::BOUND_W-1:0] w_wend;

    assign w_func   = s_axis_tuser[0];
    assign w_idx    = s_axis_tdata[9:0];
    assign w_raw_in = s_axis_tdata[23:10];
    assign w_wstart = s_axis_tdata[35:24];
    assign w_wend   = s_axis_tdata[47:36];

    // Saturate a signed bound to 0..WINDOW_DEPTH.
    function automatic logic [BW-1:0] clamp_bound(input logic signed [wwa_pkg::BOUND_W-1:0] v);
        logic signed [31:0] wide;
        wide = 32'(v);
        if (wide < 0)
            clamp_bound = '0;
        else if (wide > WINDOW_DEPTH)
            clamp_bound = BW'(WINDOW_DEPTH);
        else
            clamp_bound = BW'(wide);
    endfunction

    logic                   w_in_acc;
    logic                   w_store_ok;
    logic [SAMPLE_BITS-1:0] w_raw;
    logic [SAMPLE_BITS-1:0] w_ped;
    logic signed [SW-1:0]   w_store_val;
    logic [BW-1:0]          w_start;
    logic [BW-1:0]          w_end;
    logic                   w_nonempty;

    assign w_in_acc    = s_axis_tvalid && s_axis_tready;
    assign w_store_ok  = 32'(w_idx) < WINDOW_DEPTH;
    assign w_raw       = SAMPLE_BITS'(w_raw_in);
    assign w_ped       = SAMPLE_BITS'(r_pedestal);
    assign w_store_val = signed'({1'b0, w_raw}) - signed'({1'b0, w_ped});
    assign w_start     = clamp_bound(w_wstart);
    assign w_end       = clamp_bound(w_wend);
    assign w_nonempty  = w_end > w_start;

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    t_state                   r_state;
    logic [AW-1:0]            r_clr_ptr;
    logic [BW-1:0]            r_start;
    logic [BW-1:0]            r_end;
    logic [BW-1:0]            r_ptr;
    logic [BW-1:0]            r_count;
    logic                     r_nonempty;
    logic                     r_rd_vld;
    logic [AW-1:0]            r_rd_idx;
    logic signed [SW-1:0]     r_rd_data;
    logic                     r_first;
    logic signed [SW-1:0]     r_pk;
    logic [AW-1:0]            r_pidx;
    logic [ALU_W-1:0]         r_acc;
    logic signed [ACC_W-1:0]  r_sum;
    logic                     r_neg;
    logic [ACC_W-1:0]         r_quo;
    logic [BW-1:0]            r_rem;
    logic [ALU_W-1:0]         r_mcand;
    logic [wwa_pkg::PERIOD_W-1:0] r_mplier;
    logic [CNT_W-1:0]         r_cnt;
    logic [wwa_pkg::INT_W-1:0]    r_integral;

    // Output register
    logic                              r_out_valid;
    logic signed [wwa_pkg::SUM_W-1:0]  r_o_sum;
    logic signed [wwa_pkg::INT_W-1:0]  r_o_int;
    logic signed [wwa_pkg::MEAN_W-1:0] r_o_mean;
    logic                              r_o_mean_ok;
    logic signed [wwa_pkg::PEAK_W-1:0] r_o_pk;
    logic [wwa_pkg::IDX_W-1:0]         r_o_pidx;
    logic [wwa_pkg::TIME_W-1:0]        r_o_ptime;
    logic                              r_o_peak_ok;

    // ------------------------------------------------------------------
    // Waveform memory: one write port, one registered read port
    // ------------------------------------------------------------------
    logic signed [SW-1:0] r_mem [WINDOW_DEPTH];
    logic                 w_mem_we;
    logic [AW-1:0]        w_mem_waddr;
    logic signed [SW-1:0] w_mem_wdata;
    logic                 w_rd_en;

    assign w_mem_we    = (r_state == ST_CLEAR) ||
                         (w_in_acc && (w_func == wwa_pkg::FUNC_STORE) && w_store_ok);
    assign w_mem_waddr = (r_state == ST_CLEAR) ? r_clr_ptr : AW'(w_idx);
    assign w_mem_wdata = (r_state == ST_CLEAR) ? '0 : w_store_val;
    assign w_rd_en     = (r_state == ST_WALK) && (r_ptr != r_end);

    always_ff @(posedge i_clk) begin
        if (w_mem_we)
            r_mem[w_mem_waddr] <= w_mem_wdata;
        if (w_rd_en)
            r_rd_data <= r_mem[r_ptr[AW-1:0]];
    end

    // ------------------------------------------------------------------
    // Shared adder: accumulate in the walk, trial subtract in the division,
    // partial-product add in both multiplications.
    // ------------------------------------------------------------------
    logic [ALU_W-1:0] w_alu_a;
    logic [ALU_W-1:0] w_alu_b;
    logic             w_alu_sub;
    logic [ALU_W-1:0] w_alu_y;

    always_comb begin
        w_alu_a   = r_acc;
        w_alu_b   = '0;
        w_alu_sub = 1'b0;
        unique case (r_state)
            ST_WALK: w_alu_b = ALU_W'(r_rd_data);
            ST_DIV: begin
                w_alu_a   = ALU_W'({r_rem, r_quo[ACC_W-1]});
                w_alu_b   = ALU_W'(r_count);
                w_alu_sub = 1'b1;
            end
            ST_INT, ST_TIME: w_alu_b = r_mcand;
            default: ;
        endcase
    end

    assign w_alu_y = w_alu_a + (w_alu_sub ? ~w_alu_b : w_alu_b) + ALU_W'(w_alu_sub);

    logic             w_div_ok;
    logic [ALU_W-1:0] n_acc;
    logic [ACC_W-1:0] w_sum_mag;
    logic [wwa_pkg::MEAN_W-1:0] w_mean_mag;

    // Trial subtract fits: a negative result shows in the top bit.
    assign w_div_ok   = !w_alu_y[ALU_W-1];
    assign n_acc      = r_mplier[0] ? w_alu_y : r_acc;
    assign w_sum_mag  = r_acc[ACC_W-1] ? (~r_acc[ACC_W-1:0] + ACC_W'(1)) : r_acc[ACC_W-1:0];
    assign w_mean_mag = wwa_pkg::MEAN_W'(r_quo);

    // ------------------------------------------------------------------
    // Sequencer, datapath and output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_ptr   <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_vld <= w_rd_en;
            if (r_out_valid && m_axis_tready)
                r_out_valid <= 1'b0;

            unique case (r_state)
                ST_CLEAR: begin
                    r_clr_ptr <= r_clr_ptr + AW'(1);
                    if (r_clr_ptr == AW'(WINDOW_DEPTH - 1))
                        r_state <= ST_IDLE;
                end

                ST_IDLE: begin
                    // Stores end in the memory write; nonempty queries start a walk.
                    if (w_in_acc && (w_func == wwa_pkg::FUNC_QUERY)) begin
                        r_start    <= w_start;
                        r_end      <= w_end;
                        r_ptr      <= w_start;
                        r_count    <= w_end - w_start;
                        r_nonempty <= w_nonempty;
                        r_first    <= 1'b1;
                        r_acc      <= '0;
                        r_state    <= w_nonempty ? ST_WALK : ST_DONE;
                    end
                end

                ST_WALK: begin
                    if (w_rd_en)
                        r_ptr <= r_ptr + BW'(1);
                    r_rd_idx <= r_ptr[AW-1:0];
                    if (r_rd_vld) begin
                        r_acc   <= w_alu_y;
                        r_first <= 1'b0;
                        // Strict compare keeps the lowest index on a tie.
                        if (r_first || (r_rd_data > r_pk)) begin
                            r_pk   <= r_rd_data;
                            r_pidx <= r_rd_idx;
                        end
                    end
                    if (!w_rd_en && !r_rd_vld) begin
                        r_sum   <= r_acc[ACC_W-1:0];
                        r_neg   <= r_acc[ACC_W-1];
                        r_quo   <= w_sum_mag;
                        r_rem   <= '0;
                        r_cnt   <= CNT_W'(ACC_W - 1);
                        r_state <= ST_DIV;
                    end
                end

                ST_DIV: begin
                    r_rem <= w_div_ok ? w_alu_y[BW-1:0] : {r_rem[BW-2:0], r_quo[ACC_W-1]};
                    r_quo <= {r_quo[ACC_W-2:0], w_div_ok};
                    r_cnt <= r_cnt - CNT_W'(1);
                    if (r_cnt == '0) begin
                        r_acc    <= '0;
                        r_mcand  <= ALU_W'(r_sum);
                        r_mplier <= r_period;
                        r_cnt    <= CNT_W'(wwa_pkg::PERIOD_W - 1);
                        r_state  <= ST_INT;
                    end
                end

                ST_INT: begin
                    r_acc    <= n_acc;
                    r_mcand  <= r_mcand << 1;
                    r_mplier <= r_mplier >> 1;
                    r_cnt    <= r_cnt - CNT_W'(1);
                    if (r_cnt == '0) begin
                        r_integral <= n_acc[wwa_pkg::INT_W-1:0];
                        r_acc      <= ALU_W'(r_tstart);
                        r_mcand    <= ALU_W'(r_pidx);
                        r_mplier   <= r_period;
                        r_cnt      <= CNT_W'(wwa_pkg::PERIOD_W - 1);
                        r_state    <= ST_TIME;
                    end
                end

                ST_TIME: begin
                    r_acc    <= n_acc;
                    r_mcand  <= r_mcand << 1;
                    r_mplier <= r_mplier >> 1;
                    r_cnt    <= r_cnt - CNT_W'(1);
                    if (r_cnt == '0)
                        r_state <= ST_DONE;
                end

                ST_DONE: begin
                    // Load the output register once it is free or being emptied.
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_o_mean_ok <= r_nonempty;
                        r_o_peak_ok <= r_nonempty;
                        if (r_nonempty) begin
                            r_o_sum   <= wwa_pkg::SUM_W'(r_sum);
                            r_o_int   <= r_integral;
                            r_o_mean  <= r_neg ? (~w_mean_mag + wwa_pkg::MEAN_W'(1))
                                               : w_mean_mag;
                            r_o_pk    <= wwa_pkg::PEAK_W'(r_pk);
                            r_o_pidx  <= wwa_pkg::IDX_W'(r_pidx);
                            r_o_ptime <= r_acc[wwa_pkg::TIME_W-1:0];
                        end else begin
                            r_o_sum   <= '0;
                            r_o_int   <= '0;
                            r_o_mean  <= '0;
                            r_o_pk    <= '0;
                            r_o_pidx  <= '0;
                            r_o_ptime <= '0;
                        end
                        r_state <= ST_IDLE;
                    end
                end

                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Ports
    // ------------------------------------------------------------------
    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{wwa_pkg::OUT_PAD_W{1'b0}}, r_o_ptime, r_o_pidx, r_o_pk,
                            r_o_mean, r_o_int, r_o_sum};
    assign m_axis_tuser  = {r_o_peak_ok, r_o_mean_ok};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `WWA_ASSERT_SAME(a_walk_ptr_bound, i_clk, i_rst_n,
        r_state == ST_WALK, r_ptr <= r_end, "read pointer passed window end")
    `WWA_ASSERT_SAME(a_div_rem_bound, i_clk, i_rst_n,
        r_state == ST_DIV, r_rem < r_count, "division remainder not below count")
    `WWA_ASSERT_SAME(a_peak_in_window, i_clk, i_rst_n,
        (r_state == ST_DONE) && r_nonempty, (r_pidx >= r_start) && (r_pidx < r_end),
        "peak index outside window")
    `WWA_ASSERT_SAME(a_result_from_done, i_clk, i_rst_n,
        $rose(r_out_valid), $past(r_state == ST_DONE),
        "result appeared without a finished query")

endmodule

`default_nettype wire

// ===== tb/sv/waveform_window_analyzer_test.sv =====
`timescale 1ns / 1ps

module waveform_window_analyzer_test;

    localparam int DEPTH        = wwa_pkg::DEF_WINDOW_DEPTH;
    localparam int DRAIN_CYCLES = 8;      // stores settle in the memory write; keep a margin
    localparam int STALL_LIMIT  = 20000;  // clearing pass, full-window query and stalls
    localparam int RANDOM_ITEMS = 1330;
    localparam int PHASES       = 8;

    // Index past the register list; writes there must be dropped
    localparam logic [wwa_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef logic signed [wwa_pkg::BOUND_W-1:0] t_bound;

    // Bit patterns of one result item, at the widths of the result port
    typedef struct {
        logic [wwa_pkg::SUM_W-1:0]  sum;
        logic [wwa_pkg::INT_W-1:0]  integral;
        logic [wwa_pkg::MEAN_W-1:0] mean;
        logic                       mean_ok;
        logic [wwa_pkg::PEAK_W-1:0] peak;
        logic [wwa_pkg::IDX_W-1:0]  peak_idx;
        logic [wwa_pkg::TIME_W-1:0] peak_time;
        logic                       peak_ok;
    } t_window_result;

    logic                           i_clk         = 1'b0;
    logic                           i_rst_n       = 1'b0;
    logic                           i_cfg_wr_en   = 1'b0;
    logic [wwa_pkg::CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [wwa_pkg::CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [wwa_pkg::IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [wwa_pkg::IN_USER_W-1:0]  s_axis_tuser  = '0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [wwa_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic [wwa_pkg::OUT_USER_W-1:0] m_axis_tuser;

    // Shadow of the waveform store and of the registers
    logic signed [wwa_pkg::PEAK_W-1:0] sample_copy [DEPTH];
    logic [wwa_pkg::PED_W-1:0]         pedestal_reg = '0;
    logic [wwa_pkg::PERIOD_W-1:0]      period_reg   = wwa_pkg::PERIOD_W'(1);
    logic [wwa_pkg::TSTART_W-1:0]      tstart_reg   = '0;

    t_window_result expected_windows [$];
    int             error_count = 0;
    int             idle_cycles = 0;
    int             rx_wait     = 0;
    bit             tx_steady   = 1'b0;  // sender: no gaps between items
    bit             rx_steady   = 1'b0;  // receiver: never stall

    waveform_window_analyzer DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #6 i_clk = ~i_clk;

    // Work out the result of a window query from the shadow store.
    // Bounds saturate to 0..DEPTH; an empty or reversed window yields all zeros.
    function automatic t_window_result analyze_window(t_bound ws, t_bound we);
        t_window_result r;
        longint lo, hi, acc, top, top_idx, k;
        lo = (ws < 0) ? 0 : (ws > DEPTH) ? DEPTH : longint'(ws);
        hi = (we < 0) ? 0 : (we > DEPTH) ? DEPTH : longint'(we);
        r = '{default: '0};
        if (hi > lo) begin
            acc     = 0;
            top     = longint'(sample_copy[lo]);
            top_idx = lo;
            for (k = lo; k < hi; k++) begin
                acc += longint'(sample_copy[k]);
                // strict compare: on a tie the lowest index stays
                if (longint'(sample_copy[k]) > top) begin
                    top     = longint'(sample_copy[k]);
                    top_idx = k;
                end
            end
            r.sum       = wwa_pkg::SUM_W'(acc);
            r.integral  = wwa_pkg::INT_W'(acc * longint'(period_reg));
            r.mean      = wwa_pkg::MEAN_W'(acc / (hi - lo));  // truncates toward zero
            r.mean_ok   = 1'b1;
            r.peak      = wwa_pkg::PEAK_W'(top);
            r.peak_idx  = wwa_pkg::IDX_W'(top_idx);
            r.peak_time = wwa_pkg::TIME_W'(longint'(tstart_reg)
                                           + longint'(period_reg) * top_idx);
            r.peak_ok   = 1'b1;
        end
        return r;
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            error_count++;
        end
    endfunction

    function automatic t_bound random_bound();
        return t_bound'(int'($urandom_range(0, DEPTH + 2)) - 1);
    endfunction

    // Mix of rail values, near-equal values for peak ties and plain noise
    function automatic logic [wwa_pkg::RAW_W-1:0] pick_raw();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return wwa_pkg::RAW_W'($urandom_range(8000, 8002));
            default: return wwa_pkg::RAW_W'($urandom);
        endcase
    endfunction

    // Offer one item, hold it until taken, then update the shadow state.
    task automatic send_item(logic func, logic [wwa_pkg::IDX_W-1:0] idx,
                             logic [wwa_pkg::RAW_W-1:0] raw, t_bound ws, t_bound we);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {we, ws, raw, idx};
        s_axis_tuser  <= func;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (func == wwa_pkg::FUNC_STORE)
            sample_copy[idx] = $signed({1'b0, raw}) - $signed({1'b0, pedestal_reg});
        else
            expected_windows.insert(expected_windows.size(), analyze_window(ws, we));
    endtask

    // Window fields of a store item are don't-care: fill them with noise
    task automatic store_sample(int idx, logic [wwa_pkg::RAW_W-1:0] raw);
        send_item(wwa_pkg::FUNC_STORE, wwa_pkg::IDX_W'(idx), raw, random_bound(),
                  random_bound());
    endtask

    task automatic query_window(int ws, int we);
        send_item(wwa_pkg::FUNC_QUERY, wwa_pkg::IDX_W'($urandom), wwa_pkg::RAW_W'($urandom),
                  t_bound'(ws), t_bound'(we));
    endtask

    // Drain, then write all registers plus the unused index. Upper data bits
    // beyond each register's width are passed through to check they are dropped.
    task automatic program_regs(logic [31:0] ped_word, logic [31:0] period_word,
                                logic [31:0] tstart_word);
        s_axis_tvalid <= 1'b0;
        while (expected_windows.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= wwa_pkg::CFG_PEDESTAL;
        i_cfg_data  <= ped_word;
        @(posedge i_clk);
        pedestal_reg = ped_word[wwa_pkg::PED_W-1:0];
        i_cfg_index <= wwa_pkg::CFG_PERIOD;
        i_cfg_data  <= period_word;
        @(posedge i_clk);
        period_reg = period_word[wwa_pkg::PERIOD_W-1:0];
        i_cfg_index <= wwa_pkg::CFG_TSTART;
        i_cfg_data  <= tstart_word;
        @(posedge i_clk);
        tstart_reg = tstart_word[wwa_pkg::TSTART_W-1:0];
        i_cfg_index <= CFG_SPARE;
        i_cfg_data  <= $urandom;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // Store is zero after reset: full and empty windows before any write
    task automatic test_cleared_store();
        query_window(0, DEPTH);
        query_window(5, 5);
    endtask

    // Clamping of both bounds, empty and reversed windows, tie across the whole store
    task automatic test_window_bounds();
        store_sample(0, '1);
        store_sample(DEPTH - 1, '1);
        store_sample(512, wwa_pkg::RAW_W'(1));
        query_window(-1, DEPTH + 1);
        query_window(DEPTH, DEPTH + 1);
        query_window(-1, 0);
        query_window(DEPTH - 1, DEPTH + 1);
        query_window(700, 300);
    endtask

    // Register extremes: full pedestal, zero period, largest period and start time
    task automatic test_register_extremes();
        program_regs(32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0001);
        store_sample(2, '0);
        store_sample(3, '1);
        query_window(2, 4);
        program_regs(32'hFFFF_C000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        query_window(DEPTH - 1, DEPTH);
        query_window(0, DEPTH);
    endtask

    // Samples under the pedestal go negative; equal peaks resolve to the lowest index
    task automatic test_negative_peak_tie();
        program_regs(32'd100, 32'd3, 32'd1000);
        store_sample(40, wwa_pkg::RAW_W'(0));
        store_sample(41, wwa_pkg::RAW_W'(57));
        store_sample(42, wwa_pkg::RAW_W'(57));
        store_sample(43, wwa_pkg::RAW_W'(20));
        query_window(40, 44);
        query_window(40, 41);
    endtask

    // Bursts of stores with a query around them, mixed with lone stores
    // and short or arbitrary windows. Each phase reprograms the registers
    // and sets the idling pattern of both sides.
    task automatic test_random_traffic();
        int          phase, sent, pick, base, len, lo, hi, k;
        logic [31:0] ped_word, period_word, tstart_word;
        for (phase = 0; phase < PHASES; phase++) begin
            ped_word    = (phase % 4 == 0) ? 32'd0 :
                          (phase % 4 == 1) ? {2'($urandom_range(0, 3)), 30'h3FFF} :
                          {18'($urandom), 14'($urandom)};
            period_word = (phase == 3)     ? 32'd0 :
                          (phase % 3 == 1) ? 32'h0000_FFFF :
                          {16'($urandom), 16'($urandom_range(1, 65535))};
            tstart_word = (phase % 2 == 1) ? 32'hFFFF_FFFF : $urandom;
            program_regs(ped_word, period_word, tstart_word);
            tx_steady = (phase % 4 == 1) || (phase % 4 == 2);
            rx_steady = (phase % 4 == 1) || (phase % 4 == 3);
            sent = 0;
            while (sent < RANDOM_ITEMS / PHASES) begin
                pick = $urandom_range(0, 99);
                if (pick < 12) begin
                    base = $urandom_range(0, DEPTH - 1);
                    len  = $urandom_range(4, 24);
                    for (k = 0; k < len; k++)
                        store_sample((base + k) % DEPTH, pick_raw());
                    lo = base - int'($urandom_range(0, 1));
                    hi = base + len + int'($urandom_range(0, 1));
                    if (hi > DEPTH + 1)
                        hi = DEPTH + 1;
                    query_window(lo, hi);
                    sent += len + 1;
                end else if (pick < 80) begin
                    store_sample(int'($urandom_range(0, DEPTH - 1)), pick_raw());
                    sent++;
                end else if (pick < 95) begin
                    lo = int'($urandom_range(0, DEPTH + 2)) - 1;
                    hi = lo + int'($urandom_range(0, 40)) - 3;
                    if (hi > DEPTH + 1)
                        hi = DEPTH + 1;
                    if (hi < -1)
                        hi = -1;
                    query_window(lo, hi);
                    sent++;
                end else begin
                    send_item(wwa_pkg::FUNC_QUERY, wwa_pkg::IDX_W'($urandom),
                              wwa_pkg::RAW_W'($urandom), random_bound(), random_bound());
                    sent++;
                end
            end
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // Result side: stall at random after each taken item, unless rx_steady is set
    always @(posedge i_clk) begin
        int rx_draw;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_wait       <= 0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            if (rx_steady) begin
                m_axis_tready <= 1'b1;
                rx_wait       <= 0;
            end else begin
                rx_draw        = $urandom_range(0, 11);
                rx_wait       <= rx_draw;
                m_axis_tready <= (rx_draw == 0);
            end
        end else if (rx_wait > 0) begin
            m_axis_tready <= (rx_wait == 1);
            rx_wait       <= rx_wait - 1;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Compare each taken result with the oldest pending query
    always @(posedge i_clk) begin
        t_window_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_windows.size() == 0) begin
                $error("result item with no query pending");
                error_count++;
            end else begin
                want = expected_windows.pop_front();
                check_field("window_sum",      64'(want.sum),       64'(m_axis_tdata[24:0]));
                check_field("window_integral", 64'(want.integral),  64'(m_axis_tdata[65:25]));
                check_field("window_mean",     64'(want.mean),      64'(m_axis_tdata[80:66]));
                check_field("mean_ok",         64'(want.mean_ok),   64'(m_axis_tuser[0]));
                check_field("peak_value",      64'(want.peak),      64'(m_axis_tdata[95:81]));
                check_field("peak_index",      64'(want.peak_idx),  64'(m_axis_tdata[105:96]));
                check_field("peak_time",       64'(want.peak_time),
                            64'(m_axis_tdata[138:106]));
                check_field("peak_ok",         64'(want.peak_ok),   64'(m_axis_tuser[1]));
            end
        end
    end

    // Abort when neither side moves for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || i_cfg_wr_en)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("waveform_window_analyzer_test: FAIL");
                $finish;
            end
        end
    end

    initial begin
        foreach (sample_copy[k])
            sample_copy[k] = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_cleared_store();
        test_window_bounds();
        test_register_extremes();
        test_negative_peak_tie();
        test_random_traffic();
        s_axis_tvalid <= 1'b0;
        while (expected_windows.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("waveform_window_analyzer_test: PASS");
        else
            $display("waveform_window_analyzer_test: FAIL");
        $finish;
    end

endmodule
